// ----- hdl/itrp_pkg.sv -----
// Shared types, codes and helpers for the interval timer register port.
// No dependencies; imported by interval_timer_register_port_core.
`default_nettype none

package itrp_pkg;

   localparam int unsigned NUM_CHANNELS = 3;
   localparam int unsigned COUNT_WIDTH  = 17;
   localparam int unsigned RELOAD_WIDTH = 16;

   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic [RELOAD_WIDTH-1:0] reload_type;
   typedef logic [1:0]              chan_sel_type;
   typedef logic [1:0]              access_type;

   // Bus access kinds.
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Port offsets; ports below PORT_CONTROL address counter channels.
   localparam chan_sel_type PORT_CONTROL = 2'd3;

   // Access field of the control word (bits 5:4).
   localparam access_type ACCESS_LATCH = 2'd0;
   localparam access_type ACCESS_LOW   = 2'd1;
   localparam access_type ACCESS_HIGH  = 2'd2;
   localparam access_type ACCESS_WORD  = 2'd3;

   // Channel select value that means a read-back command.
   localparam chan_sel_type SEL_READBACK = 2'd3;

   localparam count_type  COUNT_WRAP   = 17'h10000;
   localparam count_type  COUNT_RESET  = 17'h0FFFF;
   localparam reload_type RELOAD_RESET = 16'hFFFF;

   // A reload of zero counts the full range.
   function automatic count_type reload_to_count(input reload_type r);
      count_type c;
      c = (r == '0) ? COUNT_WRAP : {1'b0, r};
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/interval_timer_register_port_core.sv -----
// Register port of a three-channel 8254-style interval timer.
// Depends on itrp_pkg for codes, widths and the reload-to-count helper.
`default_nettype none

// Each request item is one byte-wide bus access, a read or a write to port 0..3, and
// produces exactly one response item carrying the read byte (zero for writes). Ports
// 0..2 load and read the counter channels by low byte, high byte or low-then-high;
// port 3 takes control words (latch a count or set the access mode) and reads back the
// last control byte. The channel registers update at the accepting edge and the
// response is held in an output register, so a new request is taken every cycle as
// long as the response side keeps up. There is no count-down, gate or output; the
// mode and BCD fields of a control word have no effect.
module interval_timer_register_port_core
   import itrp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] write_data
   input  wire logic [2:0] req_tuser,   // [0] opcode, [2:1] port
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [7:0] read_data
);

   count_type    count_ff    [NUM_CHANNELS];
   count_type    count_in    [NUM_CHANNELS];
   reload_type   reload_ff   [NUM_CHANNELS];
   reload_type   reload_in   [NUM_CHANNELS];
   count_type    latch_ff    [NUM_CHANNELS];
   count_type    latch_in    [NUM_CHANNELS];
   logic         latched_ff  [NUM_CHANNELS];
   logic         latched_in  [NUM_CHANNELS];
   logic         low_next_ff [NUM_CHANNELS];
   logic         low_next_in [NUM_CHANNELS];
   access_type   access_ff   [NUM_CHANNELS];
   access_type   access_in   [NUM_CHANNELS];
   logic [7:0]   control_ff;
   logic [7:0]   control_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic [7:0]   rsp_data_ff;
   logic [7:0]   rsp_data_in;

   logic         accept;
   logic         op;
   chan_sel_type port;
   logic [7:0]   wdata;
   chan_sel_type ctl_sel;
   count_type    read_value;

   assign op      = req_tuser[0];
   assign port    = req_tuser[2:1];
   assign wdata   = req_tdata;
   assign ctl_sel = wdata[7:6];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      count_in    = count_ff;
      reload_in   = reload_ff;
      latch_in    = latch_ff;
      latched_in  = latched_ff;
      low_next_in = low_next_ff;
      access_in   = access_ff;
      control_in  = control_ff;
      rsp_data_in = rsp_data_ff;
      read_value  = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         if (op == OP_WRITE) begin
            if (port == PORT_CONTROL) begin
               control_in = wdata;
               if (ctl_sel != SEL_READBACK) begin
                  if (wdata[5:4] == ACCESS_LATCH) begin
                     latch_in[ctl_sel]   = count_ff[ctl_sel];
                     latched_in[ctl_sel] = 1'b1;
                  end else begin
                     access_in[ctl_sel] = wdata[5:4];
                  end
                  low_next_in[ctl_sel] = 1'b1;
               end
            end else begin
               unique case (access_ff[port])
                  // Low-byte access loads the whole reload with a zero high byte.
                  ACCESS_LOW: begin
                     reload_in[port] = {8'h00, wdata};
                     count_in[port]  = reload_to_count({8'h00, wdata});
                  end
                  ACCESS_HIGH: begin
                     reload_in[port] = {wdata, 8'h00};
                     count_in[port]  = reload_to_count({wdata, 8'h00});
                  end
                  ACCESS_WORD: begin
                     if (low_next_ff[port]) begin
                        reload_in[port]   = {reload_ff[port][15:8], wdata};
                        low_next_in[port] = 1'b0;
                     end else begin
                        reload_in[port]   = {wdata, reload_ff[port][7:0]};
                        count_in[port]    = reload_to_count({wdata, reload_ff[port][7:0]});
                        low_next_in[port] = 1'b1;
                     end
                  end
                  // An access field of zero replaces only the low byte of the reload.
                  default: begin
                     reload_in[port] = {reload_ff[port][15:8], wdata};
                     count_in[port]  = reload_to_count({reload_ff[port][15:8], wdata});
                  end
               endcase
            end
         end else begin
            if (port == PORT_CONTROL) begin
               rsp_data_in = control_ff;
            end else begin
               read_value = latched_ff[port] ? latch_ff[port] : count_ff[port];
               unique case (access_ff[port])
                  ACCESS_HIGH: begin
                     rsp_data_in      = read_value[15:8];
                     latched_in[port] = 1'b0;
                  end
                  ACCESS_WORD: begin
                     // In word access the latch is released only once its high byte is read.
                     if (low_next_ff[port]) begin
                        rsp_data_in       = read_value[7:0];
                        low_next_in[port] = 1'b0;
                     end else begin
                        rsp_data_in       = read_value[15:8];
                        low_next_in[port] = 1'b1;
                        latched_in[port]  = 1'b0;
                     end
                  end
                  default: begin
                     rsp_data_in      = read_value[7:0];
                     latched_in[port] = 1'b0;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            count_ff[i]    <= COUNT_RESET;
            reload_ff[i]   <= RELOAD_RESET;
            latch_ff[i]    <= '0;
            latched_ff[i]  <= 1'b0;
            low_next_ff[i] <= 1'b1;
            access_ff[i]   <= ACCESS_WORD;
         end
         control_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         reload_ff    <= reload_in;
         latch_ff     <= latch_in;
         latched_ff   <= latched_in;
         low_next_ff  <= low_next_in;
         access_ff    <= access_in;
         control_ff   <= control_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // A count never goes beyond the full range of one wrap.
   assert property (@(posedge clock) disable iff (reset)
      count_ff[0] <= COUNT_WRAP && count_ff[1] <= COUNT_WRAP && count_ff[2] <= COUNT_WRAP)
      else $error("channel count beyond wrap value");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted item produced no response");

   assert property (@(posedge clock) disable iff (reset)
      accept && op == OP_WRITE |=> rsp_tdata == 8'h00)
      else $error("write access returned nonzero data");

   assert property (@(posedge clock) disable iff (reset)
      accept && op == OP_READ && port == PORT_CONTROL |=> rsp_tdata == $past(control_ff))
      else $error("control read did not return the last control byte");
`endif

endmodule

`default_nettype wire

// ----- verif/itrp_bus_checker.sv -----
// Checker for the interval timer register port: watches both streams, predicts each read byte
// and compares it with the response items. Depends on itrp_pkg for widths and codes.

module itrp_bus_checker
   import itrp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic       req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] write_data
   input  wire logic [2:0] req_tuser,   // [0] opcode, [2:1] port
   input  wire logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire logic [7:0] rsp_tdata,   // [7:0] read_data
   output int              mismatches,
   output int              awaiting
);

   count_type    live_count  [NUM_CHANNELS];
   reload_type   reload_value[NUM_CHANNELS];
   count_type    held_count  [NUM_CHANNELS];
   logic         count_held  [NUM_CHANNELS];
   logic         low_byte_due[NUM_CHANNELS];
   access_type   byte_access [NUM_CHANNELS];
   logic [2:0]   count_mode  [NUM_CHANNELS];
   logic         bcd_flag    [NUM_CHANNELS];
   logic [7:0]   last_control;
   logic [7:0]   read_bytes_due[$];

   initial begin
      mismatches = 0;
      awaiting   = 0;
   end

   function automatic logic [7:0] read_counter(input int c);
      count_type  v;
      logic [7:0] b;
      v = count_held[c] ? held_count[c] : live_count[c];
      if (v == '0)
         v = COUNT_WRAP;
      case (byte_access[c])
         ACCESS_HIGH: begin
            b = v[15:8];
            count_held[c] = 1'b0;
         end
         ACCESS_WORD: begin
            if (low_byte_due[c]) begin
               b = v[7:0];
               low_byte_due[c] = 1'b0;
            end else begin
               b = v[15:8];
               low_byte_due[c] = 1'b1;
               count_held[c] = 1'b0;
            end
         end
         // Low-byte access, and the unreachable latch code behaving the same way.
         default: begin
            b = v[7:0];
            count_held[c] = 1'b0;
         end
      endcase
      return b;
   endfunction

   function automatic void write_counter(input int c, input logic [7:0] d);
      logic commit;
      commit = 1'b1;
      case (byte_access[c])
         ACCESS_LOW:  reload_value[c] = {8'h00, d};
         ACCESS_HIGH: reload_value[c] = {d, 8'h00};
         ACCESS_WORD: begin
            if (low_byte_due[c]) begin
               reload_value[c][7:0] = d;
               low_byte_due[c] = 1'b0;
               commit = 1'b0;
            end else begin
               reload_value[c][15:8] = d;
               low_byte_due[c] = 1'b1;
            end
         end
         default:     reload_value[c][7:0] = d;
      endcase
      if (commit)
         live_count[c] = (reload_value[c] == '0) ? COUNT_WRAP : {1'b0, reload_value[c]};
   endfunction

   function automatic void write_control(input logic [7:0] d);
      int c;
      last_control = d;
      c = d[7:6];
      if (d[7:6] == SEL_READBACK)
         return;
      if (d[5:4] == ACCESS_LATCH) begin
         held_count[c] = live_count[c];
         count_held[c] = 1'b1;
      end else begin
         byte_access[c] = d[5:4];
         count_mode[c]  = d[3:1];
         bcd_flag[c]    = d[0];
      end
      low_byte_due[c] = 1'b1;
   endfunction

   function automatic logic [7:0] bus_access(input logic op, input chan_sel_type port,
                                              input logic [7:0] d);
      logic [7:0] b;
      b = 8'h00;
      if (op == OP_WRITE) begin
         if (port == PORT_CONTROL)
            write_control(d);
         else
            write_counter(port, d);
      end else begin
         if (port == PORT_CONTROL)
            b = last_control;
         else
            b = read_counter(port);
      end
      return b;
   endfunction

   always @(posedge clock) begin
      logic [7:0] want;
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            live_count[i]   = COUNT_RESET;
            reload_value[i] = RELOAD_RESET;
            held_count[i]   = '0;
            count_held[i]   = 1'b0;
            low_byte_due[i] = 1'b1;
            byte_access[i]  = ACCESS_WORD;
            count_mode[i]   = 3'd0;
            bcd_flag[i]     = 1'b0;
         end
         last_control = 8'h00;
         read_bytes_due.delete();
      end else begin
         // The response is registered, so it always belongs to an item taken earlier.
         if (rsp_tvalid && rsp_tready) begin
            if (read_bytes_due.size() == 0) begin
               $error("read_data: no item outstanding, got %02h", rsp_tdata);
               mismatches = mismatches + 1;
            end else begin
               want = read_bytes_due.pop_front();
               if (rsp_tdata !== want) begin
                  $error("read_data mismatch: expected %02h, got %02h", want, rsp_tdata);
                  mismatches = mismatches + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            read_bytes_due.push_back(bus_access(req_tuser[0], req_tuser[2:1], req_tdata));
      end
      awaiting = read_bytes_due.size();
   end

endmodule

// ----- verif/interval_timer_register_port_core_tb.sv -----
// Top of the interval timer register port testbench: clock, reset and bus access stimulus.
// Depends on itrp_pkg, interval_timer_register_port_core and itrp_bus_checker.

module interval_timer_register_port_core_tb;
   import itrp_pkg::*;

   localparam int RANDOM_ITEMS = 1200;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 20;

   localparam chan_sel_type CH0 = 2'd0;
   localparam chan_sel_type CH1 = 2'd1;
   localparam chan_sel_type CH2 = 2'd2;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] write_data
   logic [2:0] req_tuser  = 3'b000;  // [0] opcode, [2:1] port
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] read_data

   int mismatches;
   int awaiting;
   int cycles    = 0;
   int sent      = 0;
   bit send_idle = 1'b1;
   bit recv_idle = 1'b1;

   interval_timer_register_port_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   itrp_bus_checker bus_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mismatches (mismatches),
      .awaiting   (awaiting)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic logic [7:0] control_word(input chan_sel_type sel, input access_type acc,
                                               input logic [2:0] mode, input logic bcd);
      return {sel, acc, mode, bcd};
   endfunction

   // Favors the all-zero and all-one bytes; an all-zero reload hits the wrap-around count.
   function automatic logic [7:0] random_byte();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0)
         return 8'h00;
      if (pick == 1)
         return 8'hFF;
      return 8'($urandom);
   endfunction

   // Entered and left at a falling edge; valid stays high between back-to-back items.
   task automatic send_access(input logic op, input chan_sel_type port, input logic [7:0] d);
      int gap;
      gap = send_idle ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= {port, op};
      req_tdata  <= d;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sent = sent + 1;
      @(negedge clock);
   endtask

   task automatic random_sequence();
      chan_sel_type ch;
      access_type   acc;
      logic [7:0]   d;
      int           kind;
      ch   = chan_sel_type'($urandom_range(0, 2));
      kind = $urandom_range(0, 9);
      d    = 8'($urandom);
      if (kind <= 3) begin
         acc = access_type'($urandom_range(1, 3));
         d[7:6] = ch;
         d[5:4] = acc;
         send_access(OP_WRITE, PORT_CONTROL, d);
         repeat ((acc == ACCESS_WORD) ? 2 : 1) send_access(OP_WRITE, ch, random_byte());
         repeat ($urandom_range(1, 3)) send_access(OP_READ, ch, 8'($urandom));
      end else if (kind <= 5) begin
         d[7:6] = ch;
         d[5:4] = ACCESS_LATCH;
         send_access(OP_WRITE, PORT_CONTROL, d);
         repeat ($urandom_range(0, 2)) send_access(OP_WRITE, ch, random_byte());
         repeat ($urandom_range(1, 3)) send_access(OP_READ, ch, 8'($urandom));
      end else if (kind == 6) begin
         d[7:6] = SEL_READBACK;
         send_access(OP_WRITE, PORT_CONTROL, d);
         send_access(OP_READ, PORT_CONTROL, 8'($urandom));
      end else if (kind == 7) begin
         repeat ($urandom_range(1, 2)) send_access(OP_READ, ch, 8'($urandom));
      end else begin
         repeat ($urandom_range(1, 4))
            send_access(logic'($urandom_range(0, 1)), chan_sel_type'($urandom_range(0, 3)),
                        random_byte());
      end
   endtask

   // Response side, including one long hold-off that backs the block up into its input.
   initial begin
      int gap;
      int taken;
      taken = 0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (taken % 64 == 0)
            recv_idle = ($urandom_range(0, 2) != 0);
         gap = recv_idle ? $urandom_range(0, 12) : 0;
         if (taken == HOLD_AT)
            gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken = taken + 1;
         @(negedge clock);
      end
   end

   initial begin
      int directed;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset state: control byte zero, counters at 0xFFFF in low-then-high order.
      send_access(OP_READ,  PORT_CONTROL, 8'hA5);
      send_access(OP_READ,  CH0, 8'h5A);
      send_access(OP_READ,  CH0, 8'hFF);
      // Low-byte access loading zero reads back as the wrapped count.
      send_access(OP_WRITE, PORT_CONTROL, control_word(CH0, ACCESS_LOW, 3'd0, 1'b0));
      send_access(OP_WRITE, CH0, 8'h00);
      send_access(OP_READ,  CH0, 8'h00);
      send_access(OP_WRITE, PORT_CONTROL, control_word(CH1, ACCESS_HIGH, 3'd7, 1'b0));
      send_access(OP_WRITE, CH1, 8'hFF);
      send_access(OP_READ,  CH1, 8'h00);
      send_access(OP_WRITE, PORT_CONTROL, control_word(CH2, ACCESS_WORD, 3'd7, 1'b1));
      send_access(OP_WRITE, CH2, 8'h00);
      send_access(OP_WRITE, CH2, 8'h00);
      // A latched count survives a reload and is released after its high byte.
      send_access(OP_WRITE, PORT_CONTROL, control_word(CH2, ACCESS_LATCH, 3'd0, 1'b0));
      send_access(OP_WRITE, CH2, 8'h34);
      send_access(OP_WRITE, CH2, 8'h12);
      send_access(OP_READ,  CH2, 8'hFF);
      send_access(OP_READ,  CH2, 8'h00);
      send_access(OP_READ,  CH2, 8'h00);
      send_access(OP_READ,  CH2, 8'h00);
      // A read-back command only changes the control byte.
      send_access(OP_WRITE, PORT_CONTROL, control_word(SEL_READBACK, ACCESS_WORD, 3'd7, 1'b1));
      send_access(OP_READ,  PORT_CONTROL, 8'h00);
      // Latch in high-byte access is released by a single read.
      send_access(OP_WRITE, PORT_CONTROL, control_word(CH1, ACCESS_LATCH, 3'd0, 1'b0));
      send_access(OP_WRITE, CH1, 8'hAB);
      send_access(OP_READ,  CH1, 8'h00);
      send_access(OP_READ,  CH1, 8'h00);
      directed = sent;

      while (sent < directed + RANDOM_ITEMS) begin
         if ((sent - directed) % 100 < 4)
            send_idle = ($urandom_range(0, 2) != 0);
         random_sequence();
      end
      req_tvalid <= 1'b0;

      while (awaiting != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
